>>> rtl/rbes_pkg.sv
// ----------------------------------------------------------------------------
// rbes_pkg
// Shared types, constants and fixed-point helpers for the Euler step block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbes_pkg;

    localparam int TERM_UNITS = 50;
    localparam int DT_FRAC    = 16;

    localparam logic [2:0] CFG_GRAV_X  = 3'd0;
    localparam logic [2:0] CFG_GRAV_Y  = 3'd1;
    localparam logic [2:0] CFG_GRAV_Z  = 3'd2;
    localparam logic [2:0] CFG_SPIN_X  = 3'd3;
    localparam logic [2:0] CFG_SPIN_Y  = 3'd4;
    localparam logic [2:0] CFG_SPIN_Z  = 3'd5;
    localparam logic [2:0] CFG_ENABLE  = 3'd6;
    localparam logic [2:0] CFG_TERMINAL = 3'd7;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_GMUL = 16'h0002,
        S_GADD = 16'h0004,
        S_SMUL = 16'h0008,
        S_SACC = 16'h0010,
        S_LMUL = 16'h0020,
        S_CMP  = 16'h0040,
        S_ROOT = 16'h0080,
        S_DMUL = 16'h0100,
        S_DGO  = 16'h0200,
        S_DIV  = 16'h0400,
        S_PMUL = 16'h0800,
        S_PADD = 16'h1000,
        S_RMUL = 16'h2000,
        S_RADD = 16'h4000,
        S_DONE = 16'h8000
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_sd_ctl;

    // Saturate a signed 64-bit value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Product scaled by dt: round to nearest, ties up, then saturate.
    function automatic logic signed [31:0] round_dt(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [63:0] s;
        t = p + 64'sd32768;
        s = t >>> DT_FRAC;
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            r = s[32] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rbes_sqdiv.sv
// ----------------------------------------------------------------------------
// rbes_sqdiv
// Iterative integer square root and divide sharing one compare-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module rbes_sqdiv
    import rbes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_sd_ctl     i_ctl,
    input  wire logic [63:0] i_opnd,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_result
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_mode, n_mode;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_src, n_src;
    logic [34:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic [31:0] r_div, n_div;

    logic [34:0] w_a, w_b;
    logic [35:0] w_diff;
    logic        w_ge;

    // Square root brings down two bits a step, division one.
    always_comb begin
        if (r_mode) begin
            w_a = {2'b00, r_rem[31:0], r_src[63]};
            w_b = {3'b000, r_div};
        end else begin
            w_a = {r_rem[32:0], r_src[63:62]};
            w_b = {1'b0, r_q, 2'b01};
        end
        w_diff = {1'b0, w_a} - {1'b0, w_b};
        w_ge   = ~w_diff[35];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_src  = r_src;
        n_rem  = r_rem;
        n_q    = r_q;
        n_div  = r_div;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_mode = i_ctl.is_div;
            n_cnt  = 5'd31;
            n_q    = '0;
            n_div  = i_divisor;
            if (i_ctl.is_div) begin
                n_rem = {3'b000, i_opnd[63:32]};
                n_src = {i_opnd[31:0], 32'h0};
            end else begin
                n_rem = '0;
                n_src = i_opnd;
            end
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[34:0] : w_a;
            n_q   = {r_q[30:0], w_ge};
            n_src = r_mode ? {r_src[62:0], 1'b0} : {r_src[61:0], 2'b00};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_mode <= n_mode;
        r_cnt  <= n_cnt;
        r_src  <= n_src;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_div  <= n_div;
    end

    assign o_done   = r_done;
    assign o_result = r_q;

endmodule

`default_nettype wire

>>> rtl/rigid_body_euler_step_speed_clamp.sv
// ----------------------------------------------------------------------------
// rigid_body_euler_step_speed_clamp
// Semi-implicit Euler step of a 3D body with a terminal speed clamp.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  input     i_in_valid / o_in_ready, i_step_time      request in
//  result    o_out_valid / i_out_ready, o_pos/rot/vel  request out
//  config    i_cfg_we, i_cfg_index, i_cfg_data         write only
//
//  A disabled or zero-length tick goes from S_IDLE straight to S_DONE.
//  A clamping tick also waits in S_ROOT and S_DIV: the shared 33x33 multiplier
//  feeds a 32-step square root and three 32-step divides in rbes_sqdiv.
//  Reset is synchronous; it clears the state vectors, gravity and spin.
//  A new request is taken while the previous result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_euler_step_speed_clamp
    import rbes_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [16:0] i_step_time,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_pos_x,
    output logic [31:0]      o_pos_y,
    output logic [31:0]      o_pos_z,
    output logic [31:0]      o_rot_x,
    output logic [31:0]      o_rot_y,
    output logic [31:0]      o_rot_z,
    output logic [31:0]      o_vel_x,
    output logic [31:0]      o_vel_y,
    output logic [31:0]      o_vel_z,
    output logic             o_updated
);

    localparam logic [30:0] TS_RESET = 31'(TERM_UNITS << FRAC_BITS);

    t_state             r_state;
    logic signed [31:0] r_grav [3];
    logic signed [31:0] r_spin [3];
    logic               r_enable;
    logic [30:0]        r_term;
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_rot [3];
    logic [16:0]        r_dt;
    logic               r_upd;
    logic [1:0]         r_idx;
    logic [63:0]        r_sum;
    logic signed [63:0] r_prod;
    logic [31:0]        r_len;
    logic               r_out_valid;
    logic [31:0]        r_out [9];
    logic               r_out_upd;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic signed [32:0] w_vx;
    logic signed [32:0] w_mag;
    logic               w_last;
    logic               w_load;
    t_sd_ctl            w_sd_ctl;
    logic               w_sd_done;
    logic [31:0]        w_sd_res;

    assign w_vx   = {r_vel[r_idx][31], r_vel[r_idx]};
    assign w_mag  = r_vel[r_idx][31] ? -w_vx : w_vx;
    assign w_last = (r_idx == 2'd2);
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Operand select for the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_GMUL: begin
                w_ma = {r_grav[r_idx][31], r_grav[r_idx]};
                w_mb = {16'h0, r_dt};
            end
            S_SMUL: begin
                w_ma = w_mag;
                w_mb = w_mag;
            end
            S_LMUL: begin
                w_ma = {2'b00, r_term};
                w_mb = {2'b00, r_term};
            end
            S_DMUL: begin
                w_ma = w_mag;
                w_mb = {2'b00, r_term};
            end
            S_PMUL: begin
                w_ma = w_vx;
                w_mb = {16'h0, r_dt};
            end
            S_RMUL: begin
                w_ma = {r_spin[r_idx][31], r_spin[r_idx]};
                w_mb = {16'h0, r_dt};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        w_sd_ctl.start  = ((r_state == S_CMP) && (r_sum > r_prod)) || (r_state == S_DGO);
        w_sd_ctl.is_div = (r_state == S_DGO);
    end

    rbes_sqdiv u_sqdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_sd_ctl),
        .i_opnd    (r_state == S_DGO ? r_prod : r_sum),
        .i_divisor (r_len),
        .o_done    (w_sd_done),
        .o_result  (w_sd_res)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[63:0];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_term      <= TS_RESET;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            for (int k = 0; k < 3; k++) begin
                r_grav[k] <= '0;
                r_spin[k] <= '0;
                r_vel[k]  <= '0;
                r_pos[k]  <= '0;
                r_rot[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRAV_X:   r_grav[0] <= i_cfg_data;
                    CFG_GRAV_Y:   r_grav[1] <= i_cfg_data;
                    CFG_GRAV_Z:   r_grav[2] <= i_cfg_data;
                    CFG_SPIN_X:   r_spin[0] <= i_cfg_data;
                    CFG_SPIN_Y:   r_spin[1] <= i_cfg_data;
                    CFG_SPIN_Z:   r_spin[2] <= i_cfg_data;
                    CFG_ENABLE:   r_enable  <= i_cfg_data[0];
                    CFG_TERMINAL: r_term    <= i_cfg_data[30:0];
                    default:      r_enable  <= r_enable;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dt  <= i_step_time;
                        r_idx <= '0;
                        r_sum <= '0;
                        if (r_enable && (i_step_time != '0)) begin
                            r_upd   <= 1'b1;
                            r_state <= S_GMUL;
                        end else begin
                            r_upd   <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_GMUL: r_state <= S_GADD;
                S_GADD: begin
                    r_vel[r_idx] <= add_sat(r_vel[r_idx], round_dt(r_prod));
                    r_idx        <= w_last ? 2'd0 : r_idx + 2'd1;
                    r_state      <= w_last ? S_SMUL : S_GMUL;
                end
                S_SMUL: r_state <= S_SACC;
                S_SACC: begin
                    r_sum   <= r_sum + r_prod;
                    r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
                    r_state <= w_last ? S_LMUL : S_SMUL;
                end
                S_LMUL: r_state <= S_CMP;
                S_CMP: begin
                    r_state <= (r_sum > r_prod) ? S_ROOT : S_PMUL;
                end
                S_ROOT: begin
                    if (w_sd_done) begin
                        r_len   <= w_sd_res;
                        r_state <= S_DMUL;
                    end
                end
                S_DMUL: r_state <= S_DGO;
                S_DGO:  r_state <= S_DIV;
                S_DIV: begin
                    if (w_sd_done) begin
                        // The quotient never exceeds the terminal speed, so it
                        // never needs saturation when negated.
                        r_vel[r_idx] <= r_vel[r_idx][31] ? -w_sd_res : w_sd_res;
                        r_idx        <= w_last ? 2'd0 : r_idx + 2'd1;
                        r_state      <= w_last ? S_PMUL : S_DMUL;
                    end
                end
                S_PMUL: r_state <= S_PADD;
                S_PADD: begin
                    r_pos[r_idx] <= add_sat(r_pos[r_idx], round_dt(r_prod));
                    r_state      <= S_RMUL;
                end
                S_RMUL: r_state <= S_RADD;
                S_RADD: begin
                    r_rot[r_idx] <= add_sat(r_rot[r_idx], round_dt(r_prod));
                    r_idx        <= w_last ? 2'd0 : r_idx + 2'd1;
                    r_state      <= w_last ? S_DONE : S_PMUL;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end

        if (w_load) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k]     <= r_pos[k];
                r_out[3 + k] <= r_rot[k];
                r_out[6 + k] <= r_vel[k];
            end
            r_out_upd <= r_upd;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out[0];
    assign o_pos_y     = r_out[1];
    assign o_pos_z     = r_out[2];
    assign o_rot_x     = r_out[3];
    assign o_rot_y     = r_out[4];
    assign o_rot_z     = r_out[5];
    assign o_vel_x     = r_out[6];
    assign o_vel_y     = r_out[7];
    assign o_vel_z     = r_out[8];
    assign o_updated   = r_out_upd;

endmodule

`default_nettype wire
